// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ORTDL_ASSERT_AT(label, clock, reset_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!reset_n) (prop)) \
		else $error(msg);

// Same, on the block clock and reset.
`define ORTDL_ASSERT(label, prop, msg) \
	`ORTDL_ASSERT_AT(label, clk, arst_n, prop, msg)

`endif

// ----- hdl/ortdl_pkg.sv -----
package ortdl_pkg;

	localparam int SUM_W = 24;
	localparam logic [SUM_W-1:0] FIELD_MAX = 24'hFF_FFFF;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_GENE  = 1'b1;

	// broadcast control for the row of city cells
	typedef struct packed {
		logic clear;
		logic visit;
	} cell_ctl_t;

endpackage

// ----- hdl/ortdl_ram.sv -----
module ortdl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/ortdl_cell.sv -----
module ortdl_cell #(
	parameter int INDEX  = 0,
	parameter int IDX_W  = 7,
	parameter int RANK_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ortdl_pkg::cell_ctl_t ctl,
	input  logic [RANK_W-1:0]   k,
	input  logic                ge_in,
	output logic                ge_out,
	input  logic [IDX_W-1:0]    idx_in,
	output logic [IDX_W-1:0]    idx_out,
	output logic                match
);

	localparam logic [RANK_W-1:0] RANK_INIT = RANK_W'(INDEX + 1);
	localparam logic [IDX_W-1:0]  IDX_CONST = IDX_W'(INDEX);

	logic              visited_q;
	// rank of this city among the unvisited ones at or below it
	logic [RANK_W-1:0] rank_q;

	assign match   = !visited_q && (rank_q == k);
	// set in the chosen cell and every cell above it
	assign ge_out  = ge_in | match;
	assign idx_out = idx_in | (match ? IDX_CONST : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= 1'b0;
			rank_q    <= RANK_INIT;
		end else if (ctl.clear) begin
			visited_q <= 1'b0;
			rank_q    <= RANK_INIT;
		end else if (ctl.visit) begin
			if (match) begin
				visited_q <= 1'b1;
			end
			if (ge_out) begin
				rank_q <= rank_q - RANK_W'(1);
			end
		end
	end

endmodule

// ----- hdl/ortdl_div.sv -----
`include "assert_macros.svh"

module ortdl_div #(
	parameter int NUM_W = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [NUM_W-1:0]            numer,
	input  logic [ortdl_pkg::SUM_W-1:0] denom,
	output logic [NUM_W-1:0]            quo,
	output logic                        done,
	output logic                        busy
);

	localparam int SW = ortdl_pkg::SUM_W;
	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [SW:0]      rem_q;
	logic [SW-1:0]    den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [SW:0] rem_sh;
	logic [SW:0] rem_diff;
	logic        fits;

	// restoring division, one quotient bit per cycle
	assign rem_sh   = {rem_q[SW-1:0], quo_q[NUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign fits     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? rem_diff : rem_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
	assign busy = busy_q;

	`ORTDL_ASSERT(a_start_idle, start |-> !busy_q, "divider started while busy")
	`ORTDL_ASSERT(a_done_after_busy, done_q |-> ($past(busy_q) && !busy_q), "stray done")

endmodule

// ----- hdl/ordinal_tour_decode_length.sv -----
// Ordinal tour decoder with tour length and fitness.
// Input channel (in_valid/in_ready): cmd 0 writes distance[row_city][col_city]
// and gives no result; cmd 1 decodes one gene and gives one result on the
// output channel (out_valid/out_ready).
// city_count is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle; the block itself does not enforce this. A write
// also abandons the tour in progress. A distance write is done as it is taken.
// A gene goes from accept to result through accept, select in the city cell row,
// distance read and add, and output load. The last gene of a tour adds one more
// distance read and then runs the serial divider, one quotient bit per cycle.
// One item is in flight at a time; the distance table port and the select are
// shared by each gene.
// Reset clears the visited map, the tour sums and sets city_count to 2. The
// distance table is not cleared; every entry used by a tour must be written.
// A result waits in the output register while the receiver stalls; the next
// item is still taken and worked on up to its own output load.
module ordinal_tour_decode_length #(
	parameter int MAX_CITIES = 128,
	parameter int DIST_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [6:0]  row_city,
	input  logic [6:0]  col_city,
	input  logic [15:0] distance,
	input  logic [7:0]  gene,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  city,
	output logic [6:0]  position,
	output logic        last,
	output logic [23:0] tour_length,
	output logic [23:0] fitness_q16,
	output logic        gene_error
);

	`include "assert_macros.svh"

	localparam int SW     = ortdl_pkg::SUM_W;
	localparam int IDX_W  = $clog2(MAX_CITIES);
	localparam int CNT_W  = $clog2(MAX_CITIES + 1);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int NUM_W  = CNT_W + 16;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SEL  = 6'b000010,
		ST_ADD1 = 6'b000100,
		ST_ADD2 = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [7:0]        city_count_q;
	logic [7:0]        gene_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  pos_at_q;
	logic [IDX_W-1:0]  prev_q;
	logic [IDX_W-1:0]  chosen_q;
	logic [SW-1:0]     sum_q;
	logic              err_q;
	logic              last_q;

	logic              out_valid_q;
	logic [7:0]        city_q;
	logic [6:0]        position_q;
	logic              last_out_q;
	logic [23:0]       tour_length_q;
	logic [23:0]       fitness_q;
	logic              gene_error_q;

	// active city count, clamped to 2..MAX_CITIES
	logic [31:0]       cc_ext;
	logic [CNT_W-1:0]  n_act;
	logic [CNT_W-1:0]  remaining;
	logic [CNT_W-1:0]  pos_next;
	logic              is_last;
	logic [CNT_W-1:0]  k_sel;
	logic              k_err;

	ortdl_pkg::cell_ctl_t cell_ctl;
	logic [MAX_CITIES:0] ge_chain;
	logic [IDX_W-1:0]    idx_chain [MAX_CITIES+1];
	logic [MAX_CITIES-1:0] match_vec;

	logic              in_take;
	logic              out_load;
	logic              wr_en;
	logic [31:0]       row_ext;
	logic [31:0]       col_ext;
	logic [31:0]       dist_ext;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [DIST_BITS-1:0] rd_data;
	logic [33:0]       sum_wide;
	logic [SW-1:0]     sum_sat;

	logic              div_start;
	logic [SW-1:0]     div_den;
	logic [NUM_W-1:0]  div_quo;
	logic              div_done;
	logic              div_busy;
	logic [31:0]       quo_ext;
	logic [31:0]       chosen_ext;
	logic [31:0]       pos_at_ext;

	assign in_ready = (state_q == ST_IDLE);
	assign in_take  = in_valid && in_ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		cc_ext = 32'(city_count_q);
		if (cc_ext < 32'd2) begin
			n_act = CNT_W'(2);
		end else if (cc_ext > 32'(MAX_CITIES)) begin
			n_act = CNT_W'(MAX_CITIES);
		end else begin
			n_act = CNT_W'(cc_ext);
		end
	end

	assign remaining = n_act - pos_q;
	assign pos_next  = pos_q + CNT_W'(1);
	assign is_last   = (pos_next >= n_act);

	// gene zero picks the first free city, an oversized gene the last one
	always_comb begin
		if (gene_q == 8'd0) begin
			k_sel = CNT_W'(1);
			k_err = 1'b1;
		end else if (32'(gene_q) > 32'(remaining)) begin
			k_sel = remaining;
			k_err = 1'b1;
		end else begin
			k_sel = CNT_W'(gene_q);
			k_err = 1'b0;
		end
	end

	// row of city cells: visited flag and running rank per city
	assign cell_ctl.clear = cfg_wr_en || (out_load && last_q);
	assign cell_ctl.visit = (state_q == ST_SEL);
	assign ge_chain[0]    = 1'b0;
	assign idx_chain[0]   = '0;

	for (genvar i = 0; i < MAX_CITIES; i++) begin : g_cell
		ortdl_cell #(
			.INDEX (i),
			.IDX_W (IDX_W),
			.RANK_W(CNT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl),
			.k      (k_sel),
			.ge_in  (ge_chain[i]),
			.ge_out (ge_chain[i+1]),
			.idx_in (idx_chain[i]),
			.idx_out(idx_chain[i+1]),
			.match  (match_vec[i])
		);
	end

	// distance table
	assign row_ext  = 32'(row_city);
	assign col_ext  = 32'(col_city);
	assign dist_ext = 32'(distance);
	assign wr_en    = in_take && (cmd == ortdl_pkg::CMD_WRITE) &&
		(row_ext < 32'(MAX_CITIES)) && (col_ext < 32'(MAX_CITIES));

	assign rd_en   = (state_q == ST_SEL) || (state_q == ST_ADD1);
	assign rd_addr = (state_q == ST_SEL) ? {prev_q, idx_chain[MAX_CITIES]} :
		{chosen_q, IDX_W'(0)};

	ortdl_ram #(
		.WIDTH(DIST_BITS),
		.DEPTH(2 ** ADDR_W)
	) u_dist (
		.clk  (clk),
		.we   (wr_en),
		.waddr({row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]}),
		.wdata(dist_ext[DIST_BITS-1:0]),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign sum_wide = 34'(sum_q) + 34'(rd_data);
	assign sum_sat  = (sum_wide > 34'(ortdl_pkg::FIELD_MAX)) ? ortdl_pkg::FIELD_MAX :
		sum_wide[SW-1:0];

	// fitness: (n << 16) / length, a zero length divides by one
	assign div_start = (state_q == ST_ADD2);
	assign div_den   = (sum_sat == '0) ? SW'(1) : sum_sat;

	ortdl_div #(
		.NUM_W(NUM_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.numer ({n_act, 16'h0000}),
		.denom (div_den),
		.quo   (div_quo),
		.done  (div_done),
		.busy  (div_busy)
	);

	assign quo_ext    = 32'(div_quo);
	assign chosen_ext = 32'(chosen_q) + 32'd1;
	assign pos_at_ext = 32'(pos_at_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			city_count_q <= 8'd2;
			pos_q        <= '0;
			prev_q       <= '0;
			sum_q        <= '0;
			last_q       <= 1'b0;
		end else if (cfg_wr_en) begin
			city_count_q <= cfg_wr_data;
			pos_q        <= '0;
			prev_q       <= '0;
			sum_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take && (cmd == ortdl_pkg::CMD_GENE)) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					state_q <= ST_ADD1;
				end
				ST_ADD1: begin
					if (pos_q != '0) begin
						sum_q <= sum_sat;
					end
					prev_q  <= chosen_q;
					pos_q   <= pos_next;
					last_q  <= is_last;
					state_q <= is_last ? ST_ADD2 : ST_OUT;
				end
				ST_ADD2: begin
					sum_q   <= sum_sat;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							pos_q  <= '0;
							prev_q <= '0;
							sum_q  <= '0;
							last_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			gene_q <= gene;
		end
		if (state_q == ST_SEL) begin
			chosen_q <= idx_chain[MAX_CITIES];
			err_q    <= k_err;
			pos_at_q <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			city_q        <= chosen_ext[7:0];
			position_q    <= pos_at_ext[6:0];
			last_out_q    <= last_q;
			tour_length_q <= last_q ? sum_q : '0;
			gene_error_q  <= err_q;
			if (!last_q) begin
				fitness_q <= '0;
			end else if (quo_ext > 32'(ortdl_pkg::FIELD_MAX)) begin
				fitness_q <= ortdl_pkg::FIELD_MAX;
			end else begin
				fitness_q <= quo_ext[23:0];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign city        = city_q;
	assign position    = position_q;
	assign last        = last_out_q;
	assign tour_length = tour_length_q;
	assign fitness_q16 = fitness_q;
	assign gene_error  = gene_error_q;

	`ORTDL_ASSERT(a_one_match, (state_q == ST_SEL) |-> $onehot(match_vec), "select not unique")
	`ORTDL_ASSERT(a_pos_range, (state_q == ST_SEL) |-> (pos_q < n_act), "gene past tour end")
	`ORTDL_ASSERT(a_tour_clear, (out_load && last_q && !cfg_wr_en) |=> (pos_q == '0 && sum_q == '0), "tour state not cleared")
	`ORTDL_ASSERT(a_div_window, div_busy |-> (state_q == ST_DIV), "divider busy outside divide")

endmodule
